// File: hw/rtl/ja_pkg.sv
// ----------------------------------------------------------------------------
// ja_pkg: joystick angle shared definitions
// Types, register codes and the arctangent table for the cordic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ja_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_X_CENTER = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_CENTER = 1'b1;

  // register reset values
  localparam int X_CENTER_RESET = 509;
  localparam int Y_CENTER_RESET = 523;

  // fraction bits of the vector datapath
  localparam int VEC_FRAC = 24;
  // integer headroom above the deflection for cordic gain
  localparam int VEC_GUARD = 2;

  // angle output: degrees * 64, one turn is 23040
  localparam int ANGLE_BITS = 15;
  localparam logic [15:0] ANGLE_UNITS = 16'd23040;
  localparam int ACC_BITS = 32;
  localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a 32-bit binary angle, rounded
  localparam int ATAN_LEN = 24;
  localparam logic [ACC_BITS-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // control travelling with each beat down the pipe
  typedef struct packed {
    logic valid;
    logic zero;
  } ja_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/ja_stream_if.sv
// ----------------------------------------------------------------------------
// ja_stream_if: joystick angle channel interfaces
// Valid/ready channels for sample pairs in and angle results out.
// ----------------------------------------------------------------------------
`default_nettype none

// sample pair channel
interface ja_in_if #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;

  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

// result channel
interface ja_out_if #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                               valid;
  logic                               ready;
  logic signed [SAMPLE_BITS:0]        x_deflection;
  logic signed [SAMPLE_BITS:0]        y_deflection;
  logic [ja_pkg::ANGLE_BITS-1:0]      angle;

  modport source (output valid, output x_deflection, output y_deflection,
                  output angle, input ready);
  modport sink   (input valid, input x_deflection, input y_deflection,
                  input angle, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ja_prep.sv
// ----------------------------------------------------------------------------
// ja_prep: deflection and half-plane fold
// Forms center minus sample for both axes, folds the left half plane onto
// the right one and seeds the angle accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ja_prep #(
  parameter int SAMPLE_BITS = 10,
  parameter int VEC_BITS    = 37
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_in,
  output logic                               ready_up,
  input  wire logic [SAMPLE_BITS-1:0]        x_sample,
  input  wire logic [SAMPLE_BITS-1:0]        y_sample,
  input  wire logic [SAMPLE_BITS-1:0]        x_center,
  input  wire logic [SAMPLE_BITS-1:0]        y_center,
  input  wire logic                          ready_dn,
  output ja_pkg::ja_ctl_t                    ctl_out,
  output logic signed [VEC_BITS-1:0]         x_out,
  output logic signed [VEC_BITS-1:0]         y_out,
  output logic [ja_pkg::ACC_BITS-1:0]        acc_out,
  output logic signed [SAMPLE_BITS:0]        dx_out,
  output logic signed [SAMPLE_BITS:0]        dy_out
);

  localparam int DEFL_BITS = SAMPLE_BITS + 1;
  localparam int EXT_BITS  = VEC_BITS - DEFL_BITS - ja_pkg::VEC_FRAC;

  ja_pkg::ja_ctl_t                  ctl_r, ctl_nxt;
  logic signed [VEC_BITS-1:0]       x_r, x_nxt;
  logic signed [VEC_BITS-1:0]       y_r, y_nxt;
  logic [ja_pkg::ACC_BITS-1:0]      acc_r, acc_nxt;
  logic signed [DEFL_BITS-1:0]      dx_r, dx_nxt;
  logic signed [DEFL_BITS-1:0]      dy_r, dy_nxt;
  logic signed [VEC_BITS-1:0]       x_ext, y_ext;

  assign ready_up = !ctl_r.valid || ready_dn;

  // deflections, scaled vector and fold of the left half plane
  always_comb begin
    dx_nxt = $signed({1'b0, x_center}) - $signed({1'b0, x_sample});
    dy_nxt = $signed({1'b0, y_center}) - $signed({1'b0, y_sample});
    x_ext  = {{EXT_BITS{dx_nxt[DEFL_BITS-1]}}, dx_nxt, {ja_pkg::VEC_FRAC{1'b0}}};
    y_ext  = {{EXT_BITS{dy_nxt[DEFL_BITS-1]}}, dy_nxt, {ja_pkg::VEC_FRAC{1'b0}}};
    ctl_nxt.valid = valid_in;
    ctl_nxt.zero  = (dx_nxt == '0) && (dy_nxt == '0);
    if (dx_nxt[DEFL_BITS-1]) begin
      x_nxt   = -x_ext;
      y_nxt   = -y_ext;
      acc_nxt = ja_pkg::HALF_TURN;
    end else begin
      x_nxt   = x_ext;
      y_nxt   = y_ext;
      acc_nxt = '0;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_up) begin
      ctl_r <= ctl_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (ready_up) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      acc_r <= acc_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign acc_out = acc_r;
  assign dx_out  = dx_r;
  assign dy_out  = dy_r;

endmodule

`default_nettype wire

// File: hw/rtl/ja_cordic_cell.sv
// ----------------------------------------------------------------------------
// ja_cordic_cell: one vectoring micro-rotation
// Rotates the vector toward the x axis by atan(2^-STAGE) and updates the
// angle accumulator, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ja_cordic_cell #(
  parameter int SAMPLE_BITS = 10,
  parameter int VEC_BITS    = 37,
  parameter int STAGE       = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ja_pkg::ja_ctl_t               ctl_in,
  output logic                               ready_up,
  input  wire logic signed [VEC_BITS-1:0]    x_in,
  input  wire logic signed [VEC_BITS-1:0]    y_in,
  input  wire logic [ja_pkg::ACC_BITS-1:0]   acc_in,
  input  wire logic signed [SAMPLE_BITS:0]   dx_in,
  input  wire logic signed [SAMPLE_BITS:0]   dy_in,
  input  wire logic                          ready_dn,
  output ja_pkg::ja_ctl_t                    ctl_out,
  output logic signed [VEC_BITS-1:0]         x_out,
  output logic signed [VEC_BITS-1:0]         y_out,
  output logic [ja_pkg::ACC_BITS-1:0]        acc_out,
  output logic signed [SAMPLE_BITS:0]        dx_out,
  output logic signed [SAMPLE_BITS:0]        dy_out
);

  localparam logic [ja_pkg::ACC_BITS-1:0] ATAN_STEP = ja_pkg::ATAN_TURNS[STAGE];

  ja_pkg::ja_ctl_t                  ctl_r;
  logic signed [VEC_BITS-1:0]       x_r, x_nxt;
  logic signed [VEC_BITS-1:0]       y_r, y_nxt;
  logic [ja_pkg::ACC_BITS-1:0]      acc_r, acc_nxt;
  logic signed [SAMPLE_BITS:0]      dx_r, dy_r;
  logic signed [VEC_BITS-1:0]       xs, ys;

  assign ready_up = !ctl_r.valid || ready_dn;

  // micro-rotation, shifts round toward minus infinity
  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    if (!y_in[VEC_BITS-1]) begin
      x_nxt   = x_in + ys;
      y_nxt   = y_in - xs;
      acc_nxt = acc_in + ATAN_STEP;
    end else begin
      x_nxt   = x_in - ys;
      y_nxt   = y_in + xs;
      acc_nxt = acc_in - ATAN_STEP;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_up) begin
      ctl_r <= ctl_in;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (ready_up) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      acc_r <= acc_nxt;
      dx_r  <= dx_in;
      dy_r  <= dy_in;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign acc_out = acc_r;
  assign dx_out  = dx_r;
  assign dy_out  = dy_r;

endmodule

`default_nettype wire

// File: hw/rtl/ja_scale.sv
// ----------------------------------------------------------------------------
// ja_scale: binary angle to degrees * 64
// Multiplies the 32-bit turn fraction by 23040, rounds half up, wraps a full
// turn and a null vector to zero and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ja_scale #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ja_pkg::ja_ctl_t               ctl_in,
  output logic                               ready_up,
  input  wire logic [ja_pkg::ACC_BITS-1:0]   acc_in,
  input  wire logic signed [SAMPLE_BITS:0]   dx_in,
  input  wire logic signed [SAMPLE_BITS:0]   dy_in,
  input  wire logic                          ready_dn,
  output logic                               valid_out,
  output logic signed [SAMPLE_BITS:0]        dx_out,
  output logic signed [SAMPLE_BITS:0]        dy_out,
  output logic [ja_pkg::ANGLE_BITS-1:0]      angle_out
);

  localparam int PROD_BITS = ja_pkg::ACC_BITS + 16;

  ja_pkg::ja_ctl_t                  mul_ctl_r;
  logic [PROD_BITS-1:0]             prod_r;
  logic signed [SAMPLE_BITS:0]      mul_dx_r, mul_dy_r;
  logic                             mul_ready;

  logic                             out_valid_r;
  logic signed [SAMPLE_BITS:0]      out_dx_r, out_dy_r;
  logic [ja_pkg::ANGLE_BITS-1:0]    angle_r, angle_nxt;
  logic [PROD_BITS-1:0]             rounded;
  logic [15:0]                      whole;

  assign mul_ready = !out_valid_r || ready_dn;
  assign ready_up  = !mul_ctl_r.valid || mul_ready;

  // multiply stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ctl_r <= '0;
    end else if (ready_up) begin
      mul_ctl_r <= ctl_in;
    end
  end

  // multiply stage payload
  always_ff @(posedge clk) begin
    if (ready_up) begin
      prod_r   <= {16'b0, acc_in} * {{ja_pkg::ACC_BITS{1'b0}}, ja_pkg::ANGLE_UNITS};
      mul_dx_r <= dx_in;
      mul_dy_r <= dy_in;
    end
  end

  // round half up, wrap a full turn, force zero for a null vector
  always_comb begin
    rounded = prod_r + PROD_BITS'(ja_pkg::HALF_TURN);
    whole   = rounded[PROD_BITS-1:ja_pkg::ACC_BITS];
    if (mul_ctl_r.zero || (whole >= ja_pkg::ANGLE_UNITS)) begin
      angle_nxt = '0;
    end else begin
      angle_nxt = whole[ja_pkg::ANGLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mul_ready) begin
      out_valid_r <= mul_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready) begin
      angle_r  <= angle_nxt;
      out_dx_r <= mul_dx_r;
      out_dy_r <= mul_dy_r;
    end
  end

  assign valid_out = out_valid_r;
  assign dx_out    = out_dx_r;
  assign dy_out    = out_dy_r;
  assign angle_out = angle_r;

endmodule

`default_nettype wire

// File: hw/rtl/joystick_angle.sv
// ----------------------------------------------------------------------------
// joystick_angle: joystick deflection and direction
// Subtracts each sample from its configured center and finds the direction
// atan2(y, x) in degrees * 64 with a pipelined vectoring cordic.
//
//   channel  direction  handshake     payload
//   in_ch    sink       valid/ready   x_sample, y_sample
//   out_ch   source     valid/ready   x_deflection, y_deflection, angle
//   cfg_*    sink       cfg_we only   cfg_index, cfg_data
//
// One beat enters per cycle while the output is not stalled; the pipe has
// one fold stage, one cell per micro-rotation and two scaling stages.
// Every stage holds its beat while the next one is full and stalled, so
// bubbles close up and a waiting result stalls the input only once every
// stage holds a beat. Synchronous active-low reset empties the pipe and
// loads the default centers.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_angle #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ja_in_if.sink                                    in_ch,
  ja_out_if.source                                 out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [ja_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]              cfg_data
);

  localparam int NUM_CELLS = (CORDIC_STAGES < ja_pkg::ATAN_LEN) ?
                             CORDIC_STAGES : ja_pkg::ATAN_LEN;
  localparam int VEC_BITS  = SAMPLE_BITS + 1 + ja_pkg::VEC_GUARD + ja_pkg::VEC_FRAC;

  logic [SAMPLE_BITS-1:0]           x_center_r, y_center_r;

  ja_pkg::ja_ctl_t                  ctl_s [NUM_CELLS+1];
  logic                             rdy_s [NUM_CELLS+1];
  logic signed [VEC_BITS-1:0]       x_s   [NUM_CELLS+1];
  logic signed [VEC_BITS-1:0]       y_s   [NUM_CELLS+1];
  logic [ja_pkg::ACC_BITS-1:0]      acc_s [NUM_CELLS+1];
  logic signed [SAMPLE_BITS:0]      dx_s  [NUM_CELLS+1];
  logic signed [SAMPLE_BITS:0]      dy_s  [NUM_CELLS+1];

  // center registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_center_r <= SAMPLE_BITS'(ja_pkg::X_CENTER_RESET);
      y_center_r <= SAMPLE_BITS'(ja_pkg::Y_CENTER_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        ja_pkg::CFG_X_CENTER: x_center_r <= cfg_data;
        ja_pkg::CFG_Y_CENTER: y_center_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // deflection and fold
  ja_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .VEC_BITS    (VEC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (in_ch.valid),
    .ready_up (in_ch.ready),
    .x_sample (in_ch.x_sample),
    .y_sample (in_ch.y_sample),
    .x_center (x_center_r),
    .y_center (y_center_r),
    .ready_dn (rdy_s[0]),
    .ctl_out  (ctl_s[0]),
    .x_out    (x_s[0]),
    .y_out    (y_s[0]),
    .acc_out  (acc_s[0]),
    .dx_out   (dx_s[0]),
    .dy_out   (dy_s[0])
  );

  // row of micro-rotation cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    ja_cordic_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .VEC_BITS    (VEC_BITS),
      .STAGE       (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl_s[i]),
      .ready_up (rdy_s[i]),
      .x_in     (x_s[i]),
      .y_in     (y_s[i]),
      .acc_in   (acc_s[i]),
      .dx_in    (dx_s[i]),
      .dy_in    (dy_s[i]),
      .ready_dn (rdy_s[i+1]),
      .ctl_out  (ctl_s[i+1]),
      .x_out    (x_s[i+1]),
      .y_out    (y_s[i+1]),
      .acc_out  (acc_s[i+1]),
      .dx_out   (dx_s[i+1]),
      .dy_out   (dy_s[i+1])
    );
  end

  // degree scaling and output register
  ja_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_s[NUM_CELLS]),
    .ready_up  (rdy_s[NUM_CELLS]),
    .acc_in    (acc_s[NUM_CELLS]),
    .dx_in     (dx_s[NUM_CELLS]),
    .dy_in     (dy_s[NUM_CELLS]),
    .ready_dn  (out_ch.ready),
    .valid_out (out_ch.valid),
    .dx_out    (out_ch.x_deflection),
    .dy_out    (out_ch.y_deflection),
    .angle_out (out_ch.angle)
  );

endmodule

`default_nettype wire

// File: sim/joystick_angle_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_angle_tb: self-checking bench for the joystick angle block
// Drives sample pairs through the valid/ready channel under random gaps and
// stalls and rewrites both centers between phases. Each result beat is
// compared field by field with a bit-accurate cordic atan2 predictor.
// ----------------------------------------------------------------------------

module joystick_angle_tb;

  localparam int SAMPLE_BITS   = 10;
  localparam int CORDIC_STAGES = 16;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int PAIRS_PER_PHASE = 192;
  localparam int LONG_HOLD_MARK  = 300;
  localparam int LONG_HOLD_CYCLES = 300;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
  } sample_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0]     x_defl;
    logic signed [SAMPLE_BITS:0]     y_defl;
    logic [ja_pkg::ANGLE_BITS-1:0]   angle;
  } stick_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ja_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [SAMPLE_BITS-1:0]            cfg_data;

  ja_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  ja_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  joystick_angle #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_pair_t  pairs_to_send [$];
  stick_result_t results_due [$];
  sample_pair_t  next_pair;
  logic [SAMPLE_BITS-1:0] x_center_copy;
  logic [SAMPLE_BITS-1:0] y_center_copy;
  bit          in_beat_taken;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          send_burst;
  bit          recv_burst;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned pairs_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // mostly short gaps, a few long ones, none at all in burst stretches
  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // direction of (dx, dy) in degrees * 64 by vectoring cordic
  function automatic logic [ja_pkg::ANGLE_BITS-1:0] heading_of(int dx, int dy);
    longint vx, vy, sx, sy;
    logic [31:0] turn;
    logic [63:0] scaled;
    int i;
    vx = longint'(dx) * (64'sd1 << 24);
    vy = longint'(dy) * (64'sd1 << 24);
    turn = '0;
    if (dx == 0 && dy == 0) return '0;
    // left half plane: flip the vector, start half a turn around
    if (vx < 0) begin
      vx   = -vx;
      vy   = -vy;
      turn = ja_pkg::HALF_TURN;
    end
    for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx   = vx + sy;
        vy   = vy - sx;
        turn = turn + ARCTAN_STEP[i];
      end else begin
        vx   = vx - sy;
        vy   = vy + sx;
        turn = turn - ARCTAN_STEP[i];
      end
    end
    // round half up, a full turn wraps to zero
    scaled = ({32'd0, turn} * 64'd23040 + 64'h8000_0000) >> 32;
    if (scaled >= 64'd23040) scaled = '0;
    return scaled[ja_pkg::ANGLE_BITS-1:0];
  endfunction

  function automatic stick_result_t predict_result(sample_pair_t p);
    stick_result_t r;
    int dx, dy;
    dx = int'(x_center_copy) - int'(p.x);
    dy = int'(y_center_copy) - int'(p.y);
    r.x_defl = dx[SAMPLE_BITS:0];
    r.y_defl = dy[SAMPLE_BITS:0];
    r.angle  = heading_of(dx, dy);
    return r;
  endfunction

  // value within span of a center, kept inside the sample range
  function automatic logic [SAMPLE_BITS-1:0] near(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic sample_pair_t draw_pair();
    sample_pair_t p;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    p.x  = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    p.y  = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    case (kind)
      6, 7: begin
        p.x = near(int'(x_center_copy), 4);
        p.y = near(int'(y_center_copy), 4);
      end
      8: p.y = near(int'(y_center_copy), 1);
      9: p.x = near(int'(x_center_copy), 1);
      default: ;
    endcase
    return p;
  endfunction

  task automatic queue_pair(int x, int y);
    sample_pair_t p;
    p.x = x[SAMPLE_BITS-1:0];
    p.y = y[SAMPLE_BITS-1:0];
    pairs_to_send.push_back(p);
  endtask

  task automatic write_reg(logic [ja_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [SAMPLE_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ja_pkg::CFG_X_CENTER) x_center_copy = value;
    else y_center_copy = value;
  endtask

  task automatic set_centers(int xc, int yc);
    write_reg(ja_pkg::CFG_X_CENTER, xc[SAMPLE_BITS-1:0]);
    write_reg(ja_pkg::CFG_Y_CENTER, yc[SAMPLE_BITS-1:0]);
  endtask

  // sender holds off until every result is back
  task automatic drain();
    @(posedge clk);
    while (pairs_to_send.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // input beat driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat_taken) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pairs_to_send.size() != 0) begin
        next_pair = pairs_to_send.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.x_sample <= next_pair.x;
        in_ch.y_sample <= next_pair.y;
        send_gap       <= pick_gap(send_burst);
        if ($urandom_range(0, 49) == 0) send_burst <= !send_burst;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && pairs_taken >= LONG_HOLD_MARK) begin
      hold_left    <= LONG_HOLD_CYCLES;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap     <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap     <= pick_gap(recv_burst);
      if ($urandom_range(0, 63) == 0) recv_burst <= !recv_burst;
    end
  end

  // predict on each input beat, check each result beat
  always @(posedge clk) begin
    stick_result_t want;
    sample_pair_t  got;
    in_beat_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      got.x = in_ch.x_sample;
      got.y = in_ch.y_sample;
      results_due.push_back(predict_result(got));
      pairs_taken <= pairs_taken + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_ch.x_deflection !== want.x_defl) begin
          $error("x_deflection: expected %0d, got %0d", want.x_defl, out_ch.x_deflection);
          mismatches++;
        end
        if (out_ch.y_deflection !== want.y_defl) begin
          $error("y_deflection: expected %0d, got %0d", want.y_defl, out_ch.y_deflection);
          mismatches++;
        end
        if (out_ch.angle !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, out_ch.angle);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p;
    int n;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ja_pkg::CFG_X_CENTER;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.x_sample = '0;
    in_ch.y_sample = '0;
    out_ch.ready   = 1'b0;
    x_center_copy  = SAMPLE_BITS'(ja_pkg::X_CENTER_RESET);
    y_center_copy  = SAMPLE_BITS'(ja_pkg::Y_CENTER_RESET);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset centers: zero, axes both ways, corners, near-axis points, diagonals
    queue_pair(509, 523);
    queue_pair(0, 523);
    queue_pair(1023, 523);
    queue_pair(509, 0);
    queue_pair(509, 1023);
    queue_pair(0, 0);
    queue_pair(1023, 1023);
    queue_pair(0, 1023);
    queue_pair(1023, 0);
    queue_pair(0, 524);
    queue_pair(1023, 522);
    queue_pair(508, 523);
    queue_pair(510, 524);
    queue_pair(12'h155, 12'h2AA);
    queue_pair(12'h2AA, 12'h155);
    drain();

    // centers at zero: widest negative deflections
    set_centers(0, 0);
    queue_pair(0, 0);
    queue_pair(1023, 1023);
    queue_pair(0, 1023);
    drain();

    // centers at full scale: widest positive deflections
    set_centers(1023, 1023);
    queue_pair(0, 0);
    queue_pair(1023, 0);
    drain();

    // random phases over a spread of centers
    for (p = 0; p < 6; p++) begin
      case (p)
        1: set_centers(0, 1023);
        2: set_centers(1023, 0);
        5: set_centers(ja_pkg::X_CENTER_RESET, ja_pkg::Y_CENTER_RESET);
        default: set_centers($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
      endcase
      for (n = 0; n < PAIRS_PER_PHASE; n++) pairs_to_send.push_back(draw_pair());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
